/* sv/escape_sequence_key_decoder_assert.svh */
// Assertion macros used by the top level of the escape sequence key decoder RTL
`ifndef ESCAPE_SEQUENCE_KEY_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ESCKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esckd: check failed");

// Next-cycle implication, checked out of reset
`define ESCKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esckd: check failed");

`endif

/* sv/esckd_pkg.sv */
// Types and constants of the escape sequence key decoder
package esckd_pkg;

  localparam int unsigned CSI_MAX_CHARS = 7;

  localparam int unsigned ADDR_W = 5;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SS3_ENABLE     = 3'd0;
  localparam logic [2:0] REG_ESCAPE_WAIT    = 3'd1;
  localparam logic [2:0] REG_SEQUENCE_WAIT  = 3'd2;
  localparam logic [2:0] REG_DIGIT_WAIT     = 3'd3;
  localparam logic [2:0] REG_NEWLINE_WAIT   = 3'd4;

  // Key codes
  localparam logic [8:0] KEY_RET   = 9'd13;
  localparam logic [8:0] KEY_ESC   = 9'd27;
  localparam logic [8:0] KEY_UP    = 9'h100;
  localparam logic [8:0] KEY_DOWN  = 9'h101;
  localparam logic [8:0] KEY_LEFT  = 9'h102;
  localparam logic [8:0] KEY_RIGHT = 9'h103;
  localparam logic [8:0] KEY_HOME  = 9'h104;
  localparam logic [8:0] KEY_END   = 9'h105;
  localparam logic [8:0] KEY_PGUP  = 9'h106;
  localparam logic [8:0] KEY_PGDN  = 9'h107;
  localparam logic [8:0] KEY_DEL   = 9'h108;
  localparam logic [8:0] KEY_NONE  = 9'd0;

  // Bytes of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;

  localparam logic [9:0]  PARAM_MAX = 10'd1023;
  localparam logic [15:0] WAIT_MAX  = 16'hFFFF;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_NL   = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_SS3  = 6'b001000,
    PH_CSI1 = 6'b010000,
    PH_CSIP = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] wait_count;
    logic [9:0]  param_value;
    logic [3:0]  param_chars;
    logic        param_closed;
  } dec_state_t;

  typedef struct packed {
    logic        ss3_enable;
    logic [15:0] escape_wait_ticks;
    logic [15:0] sequence_wait_ticks;
    logic [15:0] digit_wait_ticks;
    logic [15:0] newline_wait_ticks;
  } cfg_t;

endpackage

/* sv/escape_sequence_key_decoder.sv */
// Top level of the terminal escape sequence key decoder
// Decodes a stream of terminal bytes and time ticks into key codes. Each input
// item is either a received byte (in_action 0) or one elapsed tick (in_action 1);
// each item gives zero or one key on the out_ channel: the byte itself, 13 for
// Return (CR or LF, a second CR/LF inside the newline wait is swallowed), 27 for
// Escape, or 256..264 for Up, Down, Left, Right, Home, End, Page Up, Page Down and
// Delete from ESC O x and ESC [ ... sequences. An item is taken every clock cycle
// unless the input is blocked as below; it is registered in the input register,
// decoded against the sequence state once the output slot is free, and its key is
// loaded into the output register, which drives out_valid and out_key_code. A held
// result only blocks the input once both the input and output registers are full.
// Wait limits and ESC O decoding are set through the APB-style port (registers at
// 0x0..0x10); write them only while the decoder is quiet. No initialisation pass
// after reset.
module escape_sequence_key_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [7:0]                    in_rx_byte,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [8:0]                    out_key_code,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esckd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "escape_sequence_key_decoder_assert.svh"

  esckd_pkg::cfg_t       cfg;
  esckd_pkg::dec_state_t state_r;
  esckd_pkg::dec_state_t state_nxt;
  esckd_pkg::dec_state_t step_state;

  // input register
  logic       in_full_r;
  logic       in_full_nxt;
  logic       in_action_r;
  logic [7:0] in_rx_byte_r;

  // output register
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [8:0] out_key_code_r;
  logic [8:0] out_key_code_nxt;

  logic       in_take;
  logic       advance;  // output slot is free this cycle
  logic       proc;     // buffered item decoded this cycle
  logic       emit;
  logic [8:0] key;

  esckd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esckd_step u_step (
    .state_i (state_r),
    .cfg_i   (cfg),
    .action  (in_action_r),
    .rx_byte (in_rx_byte_r),
    .state_o (step_state),
    .emit    (emit),
    .key     (key)
  );

  assign advance  = !out_valid_r || out_ready;
  assign proc     = in_full_r && advance;
  assign in_ready = !in_full_r || advance;
  assign in_take  = in_valid && in_ready;

  assign out_valid    = out_valid_r;
  assign out_key_code = out_key_code_r;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (proc) begin
      in_full_nxt = 1'b0;
    end
  end

  // sequence state only moves when an item is decoded
  assign state_nxt = proc ? step_state : state_r;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_key_code_nxt = out_key_code_r;
    if (proc) begin
      out_valid_nxt    = emit;
      out_key_code_nxt = key;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.phase        <= esckd_pkg::PH_IDLE;
      state_r.wait_count   <= 16'd0;
      state_r.param_value  <= 10'd0;
      state_r.param_chars  <= 4'd0;
      state_r.param_closed <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r  <= in_action;
      in_rx_byte_r <= in_rx_byte;
    end
    out_key_code_r <= out_key_code_nxt;
  end

  // a decoded item with a key must show up in the output register
  `ESCKD_ASSERT_NEXT(a_emit_lands, proc && emit, out_valid_r && (out_key_code_r == $past(key)))
  // a buffered item is not lost while the output is blocked
  `ESCKD_ASSERT_NEXT(a_in_hold, in_full_r && !advance, in_full_r && $stable(in_rx_byte_r))
  // too-long CSI sequences are cut before the count reaches the limit
  `ESCKD_ASSERT_NOW(a_chars_bound, state_r.phase == esckd_pkg::PH_CSIP,
                    {28'd0, state_r.param_chars} < esckd_pkg::CSI_MAX_CHARS)
  // idle never carries a running wait
  `ESCKD_ASSERT_NOW(a_idle_wait, state_r.phase == esckd_pkg::PH_IDLE,
                    state_r.wait_count == 16'd0)

endmodule

/* sv/esckd_cfg.sv */
// APB-style configuration registers of the key decoder
module esckd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esckd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output esckd_pkg::cfg_t               cfg_o
);

  esckd_pkg::cfg_t cfg_r;
  esckd_pkg::cfg_t cfg_nxt;
  logic            wr_en;
  logic [2:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        esckd_pkg::REG_SS3_ENABLE:    cfg_nxt.ss3_enable          = pwdata[0];
        esckd_pkg::REG_ESCAPE_WAIT:   cfg_nxt.escape_wait_ticks   = pwdata[15:0];
        esckd_pkg::REG_SEQUENCE_WAIT: cfg_nxt.sequence_wait_ticks = pwdata[15:0];
        esckd_pkg::REG_DIGIT_WAIT:    cfg_nxt.digit_wait_ticks    = pwdata[15:0];
        esckd_pkg::REG_NEWLINE_WAIT:  cfg_nxt.newline_wait_ticks  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      esckd_pkg::REG_SS3_ENABLE:    prdata = {31'd0, cfg_r.ss3_enable};
      esckd_pkg::REG_ESCAPE_WAIT:   prdata = {16'd0, cfg_r.escape_wait_ticks};
      esckd_pkg::REG_SEQUENCE_WAIT: prdata = {16'd0, cfg_r.sequence_wait_ticks};
      esckd_pkg::REG_DIGIT_WAIT:    prdata = {16'd0, cfg_r.digit_wait_ticks};
      esckd_pkg::REG_NEWLINE_WAIT:  prdata = {16'd0, cfg_r.newline_wait_ticks};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ss3_enable          <= 1'b1;
      cfg_r.escape_wait_ticks   <= 16'd40;
      cfg_r.sequence_wait_ticks <= 16'd40;
      cfg_r.digit_wait_ticks    <= 16'd20;
      cfg_r.newline_wait_ticks  <= 16'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/esckd_step.sv */
// Next-state and key decode for one byte or tick
module esckd_step (
  input  esckd_pkg::dec_state_t state_i,
  input  esckd_pkg::cfg_t       cfg_i,
  input  logic                  action,
  input  logic [7:0]            rx_byte,
  output esckd_pkg::dec_state_t state_o,
  output logic                  emit,
  output logic [8:0]            key
);

  function automatic logic [8:0] final_letter(input logic [7:0] b);
    logic [8:0] k;
    case (b)
      esckd_pkg::CH_A: k = esckd_pkg::KEY_UP;
      esckd_pkg::CH_B: k = esckd_pkg::KEY_DOWN;
      esckd_pkg::CH_C: k = esckd_pkg::KEY_RIGHT;
      esckd_pkg::CH_D: k = esckd_pkg::KEY_LEFT;
      esckd_pkg::CH_H: k = esckd_pkg::KEY_HOME;
      esckd_pkg::CH_F: k = esckd_pkg::KEY_END;
      default:         k = esckd_pkg::KEY_ESC;
    endcase
    return k;
  endfunction

  // KEY_NONE for paste markers
  function automatic logic [8:0] tilde_key(input logic [9:0] n);
    logic [8:0] k;
    case (n)
      10'd1, 10'd7:     k = esckd_pkg::KEY_HOME;
      10'd3:            k = esckd_pkg::KEY_DEL;
      10'd4, 10'd8:     k = esckd_pkg::KEY_END;
      10'd5:            k = esckd_pkg::KEY_PGUP;
      10'd6:            k = esckd_pkg::KEY_PGDN;
      10'd200, 10'd201: k = esckd_pkg::KEY_NONE;
      default:          k = esckd_pkg::KEY_ESC;
    endcase
    return k;
  endfunction

  logic        is_nl;
  logic        is_digit;
  logic        is_semi;
  logic [15:0] limit;
  logic [15:0] wc_inc;
  logic [13:0] acc;
  logic [3:0]  chars_inc;

  assign is_nl     = (rx_byte == esckd_pkg::CH_CR) || (rx_byte == esckd_pkg::CH_LF);
  assign is_digit  = (rx_byte >= esckd_pkg::CH_0) && (rx_byte <= esckd_pkg::CH_9);
  assign is_semi   = (rx_byte == esckd_pkg::CH_SEMI);
  assign wc_inc    = (state_i.wait_count == esckd_pkg::WAIT_MAX) ?
                     state_i.wait_count : state_i.wait_count + 16'd1;
  // value*10 + digit, 14 bits hold 1023*10+9
  assign acc       = ({4'd0, state_i.param_value} << 3) + ({4'd0, state_i.param_value} << 1)
                     + {10'd0, rx_byte[3:0]};
  assign chars_inc = state_i.param_chars + 4'd1;

  always_comb begin
    case (state_i.phase)
      esckd_pkg::PH_NL:   limit = cfg_i.newline_wait_ticks;
      esckd_pkg::PH_ESC:  limit = cfg_i.escape_wait_ticks;
      esckd_pkg::PH_SS3,
      esckd_pkg::PH_CSI1: limit = cfg_i.sequence_wait_ticks;
      esckd_pkg::PH_CSIP: limit = cfg_i.digit_wait_ticks;
      default:            limit = 16'd0;
    endcase
  end

  always_comb begin
    state_o = state_i;
    emit    = 1'b0;
    key     = esckd_pkg::KEY_NONE;
    if (action) begin
      case (state_i.phase)
        esckd_pkg::PH_NL, esckd_pkg::PH_ESC, esckd_pkg::PH_SS3,
        esckd_pkg::PH_CSI1, esckd_pkg::PH_CSIP: begin
          state_o.wait_count = wc_inc;
          if (wc_inc >= limit) begin
            if (state_i.phase != esckd_pkg::PH_NL) begin
              emit = 1'b1;
              key  = esckd_pkg::KEY_ESC;
            end
            state_o.phase      = esckd_pkg::PH_IDLE;
            state_o.wait_count = 16'd0;
          end
        end
        default: begin
          state_o.phase = esckd_pkg::PH_IDLE;
        end
      endcase
    end else begin
      case (state_i.phase)
        esckd_pkg::PH_ESC: begin
          state_o.wait_count = 16'd0;
          if (rx_byte == esckd_pkg::CH_O && cfg_i.ss3_enable) begin
            state_o.phase = esckd_pkg::PH_SS3;
          end else if (rx_byte == esckd_pkg::CH_LBRK) begin
            state_o.phase = esckd_pkg::PH_CSI1;
          end else begin
            state_o.phase = esckd_pkg::PH_IDLE;
            emit = 1'b1;
            key  = esckd_pkg::KEY_ESC;
          end
        end
        esckd_pkg::PH_SS3: begin
          state_o.phase      = esckd_pkg::PH_IDLE;
          state_o.wait_count = 16'd0;
          emit = 1'b1;
          key  = final_letter(rx_byte);
        end
        esckd_pkg::PH_CSI1: begin
          state_o.wait_count = 16'd0;
          if (is_digit) begin
            state_o.phase        = esckd_pkg::PH_CSIP;
            state_o.param_value  = {6'd0, rx_byte[3:0]};
            state_o.param_chars  = 4'd1;
            state_o.param_closed = 1'b0;
            if (32'd1 >= esckd_pkg::CSI_MAX_CHARS) begin
              state_o.phase = esckd_pkg::PH_IDLE;
              emit = 1'b1;
              key  = esckd_pkg::KEY_ESC;
            end
          end else begin
            state_o.phase = esckd_pkg::PH_IDLE;
            emit = 1'b1;
            key  = final_letter(rx_byte);
          end
        end
        esckd_pkg::PH_CSIP: begin
          state_o.wait_count = 16'd0;
          if (is_digit || is_semi) begin
            if (is_semi) begin
              state_o.param_closed = 1'b1;
            end else if (!state_i.param_closed) begin
              state_o.param_value = (acc > {4'd0, esckd_pkg::PARAM_MAX}) ?
                                    esckd_pkg::PARAM_MAX : acc[9:0];
            end
            state_o.param_chars = chars_inc;
            if ({28'd0, chars_inc} >= esckd_pkg::CSI_MAX_CHARS) begin
              state_o.phase = esckd_pkg::PH_IDLE;
              emit = 1'b1;
              key  = esckd_pkg::KEY_ESC;
            end
          end else begin
            state_o.phase = esckd_pkg::PH_IDLE;
            if (rx_byte == esckd_pkg::CH_TILDE) begin
              key  = tilde_key(state_i.param_value);
              emit = (key != esckd_pkg::KEY_NONE);
            end else begin
              key  = final_letter(rx_byte);
              emit = 1'b1;
            end
          end
        end
        default: begin
          // idle, newline wait and unused codes: byte handled as from idle,
          // except a second CR/LF in the newline wait which is swallowed
          state_o.phase      = esckd_pkg::PH_IDLE;
          state_o.wait_count = 16'd0;
          if (is_nl) begin
            if (state_i.phase != esckd_pkg::PH_NL) begin
              state_o.phase = esckd_pkg::PH_NL;
              emit = 1'b1;
              key  = esckd_pkg::KEY_RET;
            end
          end else if (rx_byte == esckd_pkg::CH_ESC) begin
            state_o.phase = esckd_pkg::PH_ESC;
          end else begin
            emit = 1'b1;
            key  = {1'b0, rx_byte};
          end
        end
      endcase
    end
  end

endmodule

/* bench/escape_sequence_key_decoder_tb.sv */
// Self-checking bench for the escape sequence key decoder: directed table, random bursts
module escape_sequence_key_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no item moved on either side before the run is called hung
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned RAND_PHASES = 8;

  // One input item, with an optional hand-written expectation
  typedef struct {
    bit         act;
    logic [7:0] b;
    bit         typed;
    bit         gives;
    logic [8:0] key;
  } key_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_action = 1'b0;
  logic [7:0]                   in_rx_byte = 8'h00;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [8:0]                   out_key_code;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [esckd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  escape_sequence_key_decoder DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: configuration and sequence state as the block should hold them
  // ---------------------------------------------------------------------------
  bit          ss3_on     = 1'b1;
  logic [15:0] esc_wait   = 16'd40;
  logic [15:0] seq_wait   = 16'd40;
  logic [15:0] digit_wait = 16'd20;
  logic [15:0] nl_wait    = 16'd5;

  esckd_pkg::phase_t dec_phase  = esckd_pkg::PH_IDLE;
  logic [15:0]       tick_count = '0;
  logic [9:0]        csi_num    = '0;
  logic [3:0]        csi_len    = '0;
  bit                csi_semi   = 1'b0;

  logic [8:0]  pending_keys [$];   // keys still owed by the block, oldest first
  key_item_t   sent_items [$];     // items offered, popped as each is taken
  key_item_t   burst_q [$];        // random items waiting to be offered
  bit          failed = 1'b0;
  bit          calm = 1'b0;        // no idling on either side while set
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold = 0;

  logic [7:0]  final_letters [6] = '{esckd_pkg::CH_A, esckd_pkg::CH_B, esckd_pkg::CH_C,
                                     esckd_pkg::CH_D, esckd_pkg::CH_H, esckd_pkg::CH_F};
  int unsigned tilde_params [10] = '{1, 2, 3, 4, 5, 6, 7, 8, 200, 201};

  function automatic bit is_digit(input logic [7:0] b);
    return b >= esckd_pkg::CH_0 && b <= esckd_pkg::CH_9;
  endfunction

  // Final byte of ESC O x / ESC [ ... x; anything unknown is Escape
  function automatic logic [8:0] final_key(input logic [7:0] b);
    case (b)
      esckd_pkg::CH_A: return esckd_pkg::KEY_UP;
      esckd_pkg::CH_B: return esckd_pkg::KEY_DOWN;
      esckd_pkg::CH_C: return esckd_pkg::KEY_RIGHT;
      esckd_pkg::CH_D: return esckd_pkg::KEY_LEFT;
      esckd_pkg::CH_H: return esckd_pkg::KEY_HOME;
      esckd_pkg::CH_F: return esckd_pkg::KEY_END;
      default:         return esckd_pkg::KEY_ESC;
    endcase
  endfunction

  // Number closed by '~'; paste markers give nothing
  function automatic logic [8:0] tilde_key(input logic [9:0] n);
    case (n)
      10'd1, 10'd7:     return esckd_pkg::KEY_HOME;
      10'd3:            return esckd_pkg::KEY_DEL;
      10'd4, 10'd8:     return esckd_pkg::KEY_END;
      10'd5:            return esckd_pkg::KEY_PGUP;
      10'd6:            return esckd_pkg::KEY_PGDN;
      10'd200, 10'd201: return esckd_pkg::KEY_NONE;
      default:          return esckd_pkg::KEY_ESC;
    endcase
  endfunction

  task automatic go_to(input esckd_pkg::phase_t ph);
    dec_phase  = ph;
    tick_count = '0;
  endtask

  // Byte as seen from idle: CR/LF is Return, ESC opens a sequence, else pass through
  task automatic plain_byte(input logic [7:0] b, output bit gives, output logic [8:0] key);
    gives = 1'b0;
    key   = esckd_pkg::KEY_NONE;
    if (b == esckd_pkg::CH_CR || b == esckd_pkg::CH_LF) begin
      go_to(esckd_pkg::PH_NL);
      gives = 1'b1;
      key   = esckd_pkg::KEY_RET;
    end else if (b == esckd_pkg::CH_ESC) begin
      go_to(esckd_pkg::PH_ESC);
    end else begin
      gives = 1'b1;
      key   = {1'b0, b};
    end
  endtask

  // Advances the mirror by one item and returns the key it should produce
  task automatic decode_item(input bit act, input logic [7:0] b, output bit gives,
                             output logic [8:0] key);
    logic [15:0] lim;
    int unsigned acc;
    gives = 1'b0;
    key   = esckd_pkg::KEY_NONE;
    lim   = '0;
    if (act) begin
      case (dec_phase)
        esckd_pkg::PH_NL:   lim = nl_wait;
        esckd_pkg::PH_ESC:  lim = esc_wait;
        esckd_pkg::PH_SS3,
        esckd_pkg::PH_CSI1: lim = seq_wait;
        esckd_pkg::PH_CSIP: lim = digit_wait;
        default:            dec_phase = esckd_pkg::PH_IDLE;
      endcase
      if (dec_phase != esckd_pkg::PH_IDLE) begin
        if (tick_count != esckd_pkg::WAIT_MAX) tick_count = tick_count + 16'd1;
        // a zero limit falls out here on the first tick
        if (tick_count >= lim) begin
          if (dec_phase != esckd_pkg::PH_NL) begin
            gives = 1'b1;
            key   = esckd_pkg::KEY_ESC;
          end
          go_to(esckd_pkg::PH_IDLE);
        end
      end
    end else begin
      case (dec_phase)
        esckd_pkg::PH_NL: begin
          // second CR/LF swallowed, anything else treated as from idle
          go_to(esckd_pkg::PH_IDLE);
          if (!(b == esckd_pkg::CH_CR || b == esckd_pkg::CH_LF)) plain_byte(b, gives, key);
        end
        esckd_pkg::PH_ESC: begin
          if (b == esckd_pkg::CH_O && ss3_on) begin
            go_to(esckd_pkg::PH_SS3);
          end else if (b == esckd_pkg::CH_LBRK) begin
            go_to(esckd_pkg::PH_CSI1);
          end else begin
            go_to(esckd_pkg::PH_IDLE);
            gives = 1'b1;
            key   = esckd_pkg::KEY_ESC;
          end
        end
        esckd_pkg::PH_SS3: begin
          go_to(esckd_pkg::PH_IDLE);
          gives = 1'b1;
          key   = final_key(b);
        end
        esckd_pkg::PH_CSI1: begin
          if (is_digit(b)) begin
            go_to(esckd_pkg::PH_CSIP);
            csi_num  = 10'(b - esckd_pkg::CH_0);
            csi_len  = 4'd1;
            csi_semi = 1'b0;
          end else begin
            go_to(esckd_pkg::PH_IDLE);
            gives = 1'b1;
            key   = final_key(b);
          end
        end
        esckd_pkg::PH_CSIP: begin
          if (is_digit(b) || b == esckd_pkg::CH_SEMI) begin
            if (b == esckd_pkg::CH_SEMI) begin
              csi_semi = 1'b1;
            end else if (!csi_semi) begin
              acc     = int'(csi_num) * 10 + int'(b) - int'(esckd_pkg::CH_0);
              csi_num = (acc > 1023) ? esckd_pkg::PARAM_MAX : 10'(acc);
            end
            csi_len    = csi_len + 4'd1;
            tick_count = '0;
          end else if (b == esckd_pkg::CH_TILDE) begin
            key   = tilde_key(csi_num);
            gives = (key != esckd_pkg::KEY_NONE);
            go_to(esckd_pkg::PH_IDLE);
          end else begin
            go_to(esckd_pkg::PH_IDLE);
            gives = 1'b1;
            key   = final_key(b);
          end
        end
        default: begin
          go_to(esckd_pkg::PH_IDLE);
          plain_byte(b, gives, key);
        end
      endcase
      // overlong parameter string: Escape as soon as the count is reached
      if (dec_phase == esckd_pkg::PH_CSIP && csi_len >= esckd_pkg::CSI_MAX_CHARS) begin
        gives = 1'b1;
        key   = esckd_pkg::KEY_ESC;
        go_to(esckd_pkg::PH_IDLE);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog, all on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    key_item_t  note;
    bit         gives;
    logic [8:0] key;
    logic [8:0] want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && in_ready) begin
        note = sent_items.pop_front();
        decode_item(note.act, note.b, gives, key);
        // hand-written rows take precedence over the mirror
        if (note.typed) begin
          gives = note.gives;
          key   = note.key;
        end
        if (gives) pending_keys.push_back(key);
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        if (pending_keys.size() == 0) begin
          $display("%0t: unexpected key, expected none, got %0d", $time, out_key_code);
          failed = 1'b1;
        end else begin
          want = pending_keys.pop_front();
          if (out_key_code !== want) begin
            $display("%0t: key_code mismatch, expected %0d, got %0d",
                     $time, want, out_key_code);
            failed = 1'b1;
          end
        end
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Idle lengths: mostly none, some short, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: bursts of ready broken by stalls
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm || !out_ready) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one item; valid stays up straight into the next item when there is no gap
  task automatic push_item(input key_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sent_items.push_back(it);
    in_valid   <= 1'b1;
    in_action  <= it.act;
    in_rx_byte <= it.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Read a register and compare against the value it should hold
  task automatic reg_check(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] mask;
    mask = (idx == esckd_pkg::REG_SS3_ENABLE) ? 32'h1 : 32'hFFFF;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== ({16'h0, val} & mask)) begin
      $display("%0t: register %0d readback, expected %0d, got %0d",
               $time, idx, val & mask, prdata & mask);
      failed = 1'b1;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      esckd_pkg::REG_SS3_ENABLE:    ss3_on     = val[0];
      esckd_pkg::REG_ESCAPE_WAIT:   esc_wait   = val;
      esckd_pkg::REG_SEQUENCE_WAIT: seq_wait   = val;
      esckd_pkg::REG_DIGIT_WAIT:    digit_wait = val;
      esckd_pkg::REG_NEWLINE_WAIT:  nl_wait    = val;
      default: ;
    endcase
    reg_check(idx, val);
  endtask

  task automatic apply_setting(input bit s3, input logic [15:0] e, input logic [15:0] s,
                               input logic [15:0] d, input logic [15:0] n);
    set_reg(esckd_pkg::REG_SS3_ENABLE, {15'h0, s3});
    set_reg(esckd_pkg::REG_ESCAPE_WAIT, e);
    set_reg(esckd_pkg::REG_SEQUENCE_WAIT, s);
    set_reg(esckd_pkg::REG_DIGIT_WAIT, d);
    set_reg(esckd_pkg::REG_NEWLINE_WAIT, n);
  endtask

  // Let every owed key arrive, then give the pipeline time to empty of keyless items
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random burst builder
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    key_item_t it;
    it = '{1'b0, b, 1'b0, 1'b0, esckd_pkg::KEY_NONE};
    burst_q.push_back(it);
  endtask

  task automatic add_ticks(input int unsigned n);
    key_item_t it;
    repeat (n) begin
      it = '{1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0, esckd_pkg::KEY_NONE};
      burst_q.push_back(it);
    end
  endtask

  // Tick run long enough to hit a short wait, capped for the long ones
  function automatic int unsigned clip_ticks(input logic [15:0] lim);
    if (lim == 0) return 1;
    if (lim > 48) return 48;
    return lim;
  endfunction

  // Occasional ticks inside a sequence: up to the timeout or just short (both capped at 48), or 1 to 3
  task automatic stray_ticks(input logic [15:0] lim);
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) add_ticks(clip_ticks(lim));
    else if (r == 1 && lim > 1) add_ticks(clip_ticks(lim - 16'd1));
    else if (r < 4) add_ticks($urandom_range(1, 3));
  endtask

  function automatic logic [7:0] pick_final();
    if ($urandom_range(0, 9) < 8) return final_letters[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_params(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (i != 0) stray_ticks(digit_wait);
      add_byte(s[i]);
    end
  endtask

  task automatic build_burst();
    int unsigned kind;
    int unsigned r;
    string       s;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (kind < 20) begin
      add_ticks($urandom_range(1, 6));
    end else if (kind < 28) begin
      // Return, then a possible second CR/LF to swallow
      add_byte($urandom_range(0, 1) ? esckd_pkg::CH_CR : esckd_pkg::CH_LF);
      stray_ticks(nl_wait);
      r = $urandom_range(0, 2);
      add_byte(r == 0 ? esckd_pkg::CH_CR : r == 1 ? esckd_pkg::CH_LF :
               8'($urandom_range(0, 255)));
    end else if (kind < 38) begin
      add_byte(esckd_pkg::CH_ESC);
      stray_ticks(esc_wait);
      add_byte(esckd_pkg::CH_O);
      stray_ticks(seq_wait);
      add_byte(pick_final());
    end else if (kind < 50) begin
      add_byte(esckd_pkg::CH_ESC);
      stray_ticks(esc_wait);
      add_byte(esckd_pkg::CH_LBRK);
      stray_ticks(seq_wait);
      add_byte(pick_final());
    end else if (kind < 88) begin
      // ESC [ parameters final
      add_byte(esckd_pkg::CH_ESC);
      stray_ticks(esc_wait);
      add_byte(esckd_pkg::CH_LBRK);
      stray_ticks(seq_wait);
      case ($urandom_range(0, 3))
        0: s = $sformatf("%0d", tilde_params[$urandom_range(0, 9)]);
        1: s = $sformatf("%0d", $urandom_range(0, 99999));   // large ones saturate
        2: s = $sformatf("%0d;%0d", $urandom_range(0, 9), $urandom_range(0, 20));
        default: begin
          s = "";
          repeat ($urandom_range(5, 9))
            s = {s, ($urandom_range(0, 4) == 0) ? ";" : $sformatf("%0d", $urandom_range(0, 9))};
        end
      endcase
      add_params(s);
      stray_ticks(digit_wait);
      r = $urandom_range(0, 9);
      add_byte(r < 6 ? esckd_pkg::CH_TILDE : r < 9 ? pick_final() :
               8'($urandom_range(0, 255)));
    end else if (kind < 94) begin
      // lone ESC left to time out
      add_byte(esckd_pkg::CH_ESC);
      add_ticks(clip_ticks(esc_wait));
    end else begin
      add_byte(esckd_pkg::CH_ESC);
      stray_ticks(esc_wait);
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: run with ss3 on and every wait at 2
  // ---------------------------------------------------------------------------
  key_item_t directed_rows [26] = '{
    '{1'b1, 8'h5A,                 1'b1, 1'b0, esckd_pkg::KEY_NONE},  // tick while idle
    '{1'b0, 8'h00,                 1'b1, 1'b1, 9'h000},
    '{1'b0, 8'hFF,                 1'b1, 1'b1, 9'h0FF},
    '{1'b0, esckd_pkg::CH_CR,      1'b1, 1'b1, esckd_pkg::KEY_RET},
    '{1'b0, esckd_pkg::CH_LF,      1'b1, 1'b0, esckd_pkg::KEY_NONE},  // swallowed
    '{1'b0, esckd_pkg::CH_LF,      1'b1, 1'b1, esckd_pkg::KEY_RET},
    '{1'b1, 8'hFF,                 1'b1, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b1, 8'h00,                 1'b1, 1'b0, esckd_pkg::KEY_NONE},  // runs out quietly
    '{1'b0, esckd_pkg::CH_ESC,     1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_O,       1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_A,       1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_ESC,     1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_LBRK,    1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_0 + 8'd2, 1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_0,       1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_0 + 8'd1, 1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_TILDE,   1'b0, 1'b0, esckd_pkg::KEY_NONE},  // paste end marker
    '{1'b0, esckd_pkg::CH_ESC,     1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b1, 8'h33,                 1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b1, 8'hCC,                 1'b1, 1'b1, esckd_pkg::KEY_ESC},   // ESC timed out
    '{1'b0, esckd_pkg::CH_ESC,     1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, 8'h71,                 1'b1, 1'b1, esckd_pkg::KEY_ESC},   // unknown after ESC
    '{1'b0, esckd_pkg::CH_ESC,     1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_LBRK,    1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_0 + 8'd3, 1'b0, 1'b0, esckd_pkg::KEY_NONE},
    '{1'b0, esckd_pkg::CH_TILDE,   1'b0, 1'b0, esckd_pkg::KEY_NONE}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit          s3;
    logic [15:0] w [4];
    int unsigned sent;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of every register
    reg_check(esckd_pkg::REG_SS3_ENABLE, 16'd1);
    reg_check(esckd_pkg::REG_ESCAPE_WAIT, 16'd40);
    reg_check(esckd_pkg::REG_SEQUENCE_WAIT, 16'd40);
    reg_check(esckd_pkg::REG_DIGIT_WAIT, 16'd20);
    reg_check(esckd_pkg::REG_NEWLINE_WAIT, 16'd5);

    apply_setting(1'b1, 16'd2, 16'd2, 16'd2, 16'd2);
    foreach (directed_rows[i]) push_item(directed_rows[i]);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin  // shortest waits, ESC O off
          s3 = 1'b0;
          foreach (w[k]) w[k] = 16'd1;
        end
        1: begin  // longest waits
          s3 = 1'b1;
          foreach (w[k]) w[k] = esckd_pkg::WAIT_MAX;
        end
        2: begin  // zero waits act as one
          s3 = 1'b1;
          foreach (w[k]) w[k] = 16'd0;
        end
        3: begin
          s3 = 1'b1;
          w  = '{16'd40, 16'd40, 16'd20, 16'd5};
        end
        default: begin
          s3 = 1'($urandom_range(0, 1));
          foreach (w[k]) w[k] = 16'($urandom_range(1, 12));
        end
      endcase
      apply_setting(s3, w[0], w[1], w[2], w[3]);
      calm = (p == 4);   // one phase at full rate on both sides
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_burst();
        while (burst_q.size() != 0) begin
          push_item(burst_q.pop_front());
          sent++;
        end
      end
      settle();
      calm = 1'b0;
    end

    repeat (8) @(negedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
